>>> rtl/core/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg: shared types and constants for the fixed partition fit allocator
// Holds table geometry, action, status, policy and config codes, the channel
// payloads, the command the sequencer sends the table and the fit result.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int MAX_PARTS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_PARTS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int SIZE_BITS  = 24;
  localparam int WASTE_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 2;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_WAITING = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_FIRST = 2'd1,
    POL_NEXT  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIT_POLICY     = 1'b0,
    CFG_SPLIT_ON_WORST = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [SIZE_BITS-1:0] amount;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IDX_BITS-1:0]   slot;
    logic [SIZE_BITS-1:0]  leftover;
    logic [WASTE_BITS-1:0] waste_total;
  } out_t;

  // One transaction worth of table updates, applied in the commit cycle.
  typedef struct packed {
    logic                 clear;
    logic                 append;
    logic [SIZE_BITS-1:0] append_size;
    logic                 mark;
    logic [IDX_BITS-1:0]  mark_idx;
  } tbl_cmd_t;

  typedef struct packed {
    logic                 take;
    logic [SIZE_BITS-1:0] diff;
  } fit_res_t;

endpackage

>>> rtl/core/fixed_partition_fit_allocator_top.sv
// Add, clear and no-op pass from acceptance through the commit state into the
//   output register. Allocate first scans one table entry per cycle through the
//   shared fit unit over the filled entries, and stops early when first or next
//   fit hits; its result then takes the same path.
// One transaction at a time; in_stall stays high from acceptance
//   until the commit cycle. Reset (rst_n low, synchronous) empties the table.
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top: fixed partition placement block
// Sequencer that scans the partition table with one compare unit, commits the
// chosen placement and presents the result in an output register.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fpfa_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fpfa_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpfa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [1:0]                      policy_r;
  logic                            split_r;
  logic [1:0]                      act_r;
  logic [fpfa_pkg::SIZE_BITS-1:0]  req_r;
  logic [fpfa_pkg::IDX_BITS-1:0]   idx_r, idx_nxt;
  logic [fpfa_pkg::CNT_BITS-1:0]   step_r, step_nxt;
  logic                            found_r, found_nxt;
  logic [fpfa_pkg::IDX_BITS-1:0]   best_idx_r, best_idx_nxt;
  logic [fpfa_pkg::SIZE_BITS-1:0]  best_diff_r, best_diff_nxt;
  logic [fpfa_pkg::IDX_BITS-1:0]   rover_r, rover_nxt;
  logic [fpfa_pkg::WASTE_BITS-1:0] waste_r, waste_nxt;
  logic                            out_valid_r, out_valid_nxt;
  fpfa_pkg::out_t                  out_r, out_nxt;

  fpfa_pkg::tbl_cmd_t              cmd;
  fpfa_pkg::fit_res_t              fit;
  logic [fpfa_pkg::SIZE_BITS-1:0]  rd_size;
  logic                            rd_busy;
  logic [fpfa_pkg::CNT_BITS-1:0]   count;
  logic                            full;
  logic                            in_acc;
  logic                            commit_go;
  logic                            stop_on_hit;
  logic                            wrap;
  logic [fpfa_pkg::WASTE_BITS:0]   waste_sum;
  logic [fpfa_pkg::WASTE_BITS-1:0] waste_sat;

  // The table read is registered, so it is addressed with the next index.
  fpfa_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (idx_nxt),
    .rd_size (rd_size),
    .rd_busy (rd_busy),
    .count   (count),
    .full    (full)
  );

  fpfa_fit_unit u_fit (
    .size      (rd_size),
    .busy      (rd_busy),
    .req       (req_r),
    .found     (found_r),
    .best_diff (best_diff_r),
    .policy    (policy_r),
    .res       (fit)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign commit_go   = (state_r == S_COMMIT) && !(out_valid_r && out_stall);
  assign stop_on_hit = (policy_r == fpfa_pkg::POL_FIRST) || (policy_r == fpfa_pkg::POL_NEXT);
  assign wrap        = ({1'b0, idx_r} + 1'b1) == count;

  assign waste_sum = {1'b0, waste_r} +
                     (fpfa_pkg::WASTE_BITS+1)'(best_diff_r);
  assign waste_sat = waste_sum[fpfa_pkg::WASTE_BITS] ? '1
                                                     : waste_sum[fpfa_pkg::WASTE_BITS-1:0];

  // Sequencer: latch the transaction, scan the table, commit.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_diff_nxt = best_diff_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Rover stays below the count unless the table is empty, so next fit starts right there.
          idx_nxt   = (policy_r == fpfa_pkg::POL_NEXT) ? rover_r : '0;
          step_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = (in_data.action == fpfa_pkg::ACT_ALLOC) ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        if (step_r == count) begin
          state_nxt = S_COMMIT;
        end else begin
          if (fit.take) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = idx_r;
            best_diff_nxt = fit.diff;
            if (stop_on_hit) begin
              state_nxt = S_COMMIT;
            end
          end
          step_nxt = step_r + 1'b1;
          idx_nxt  = wrap ? '0 : idx_r + 1'b1;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commit: table command, running state and the result.
  always_comb begin
    cmd           = '0;
    rover_nxt     = rover_r;
    waste_nxt     = waste_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (commit_go) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = fpfa_pkg::ST_DONE;
      out_nxt.slot        = '0;
      out_nxt.leftover    = '0;
      out_nxt.waste_total = waste_r;
      unique case (act_r)
        fpfa_pkg::ACT_ADD: begin
          if (full) begin
            out_nxt.status = fpfa_pkg::ST_FULL;
          end else begin
            cmd.append      = 1'b1;
            cmd.append_size = req_r;
            out_nxt.slot    = count[fpfa_pkg::IDX_BITS-1:0];
          end
        end
        fpfa_pkg::ACT_ALLOC: begin
          if (found_r) begin
            cmd.mark     = 1'b1;
            cmd.mark_idx = best_idx_r;
            // Worst fit with splitting on splits off the remainder; the table drops it when full.
            cmd.append      = (policy_r == fpfa_pkg::POL_WORST) && split_r;
            cmd.append_size = best_diff_r;
            rover_nxt       = best_idx_r;
            waste_nxt       = waste_sat;
            out_nxt.slot        = best_idx_r;
            out_nxt.leftover    = best_diff_r;
            out_nxt.waste_total = waste_sat;
          end else begin
            out_nxt.status = fpfa_pkg::ST_WAITING;
          end
        end
        fpfa_pkg::ACT_CLEAR: begin
          cmd.clear           = 1'b1;
          rover_nxt           = '0;
          waste_nxt           = '0;
          out_nxt.status      = fpfa_pkg::ST_CLEARED;
          out_nxt.waste_total = '0;
        end
        fpfa_pkg::ACT_NOP: begin
          out_nxt.status = fpfa_pkg::ST_DONE;
        end
        default: out_nxt.status = fpfa_pkg::ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= fpfa_pkg::POL_BEST;
      split_r     <= 1'b1;
      rover_r     <= '0;
      waste_r     <= '0;
      found_r     <= 1'b0;
      step_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      waste_r     <= waste_nxt;
      found_r     <= found_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fpfa_pkg::CFG_FIT_POLICY:     policy_r <= cfg_data;
          fpfa_pkg::CFG_SPLIT_ON_WORST: split_r  <= cfg_data[0];
          default:                      split_r  <= split_r;
        endcase
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_data.action;
      req_r <= in_data.amount;
    end
    best_idx_r  <= best_idx_nxt;
    best_diff_r <= best_diff_nxt;
    out_r       <= out_nxt;
  end

endmodule

>>> rtl/core/fpfa_table.sv
// ----------------------------------------------------------------------------
// fpfa_table: partition table storage
// Partition sizes, in-use marks and the fill count. One entry is read per
// cycle at the scan index; updates arrive as one command per transaction.
// ----------------------------------------------------------------------------
module fpfa_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpfa_pkg::tbl_cmd_t                  cmd,
  input  logic [fpfa_pkg::IDX_BITS-1:0]       rd_idx,
  output logic [fpfa_pkg::SIZE_BITS-1:0]      rd_size,
  output logic                                rd_busy,
  output logic [fpfa_pkg::CNT_BITS-1:0]       count,
  output logic                                full
);

  logic [fpfa_pkg::SIZE_BITS-1:0] size_mem [fpfa_pkg::MAX_PARTS];
  logic [fpfa_pkg::MAX_PARTS-1:0] busy_r, busy_nxt;
  logic [fpfa_pkg::CNT_BITS-1:0]  count_r, count_nxt;
  logic [fpfa_pkg::IDX_BITS-1:0]  tail_idx;
  logic                           do_append;

  assign full      = (count_r == fpfa_pkg::CNT_BITS'(fpfa_pkg::MAX_PARTS));
  assign tail_idx  = count_r[fpfa_pkg::IDX_BITS-1:0];
  assign do_append = cmd.append && !full;
  assign count     = count_r;

  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      busy_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (cmd.mark) begin
        busy_nxt[cmd.mark_idx] = 1'b1;
      end
      if (do_append) begin
        busy_nxt[tail_idx] = 1'b0;
        count_nxt          = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
    end
  end

  // Sizes hold no reset; a scan only uses entries below the count.
  always_ff @(posedge clk) begin
    if (do_append && !cmd.clear) begin
      size_mem[tail_idx] <= cmd.append_size;
    end
  end

  // Read data shows up in the cycle after its address.
  always_ff @(posedge clk) begin
    rd_size <= size_mem[rd_idx];
    rd_busy <= busy_r[rd_idx];
  end

endmodule

>>> rtl/core/fpfa_fit_unit.sv
// ----------------------------------------------------------------------------
// fpfa_fit_unit: shared fit compare unit
// Subtracts the request from one partition size, checks the fit and compares
// the leftover against the best candidate so far under the active policy.
// ----------------------------------------------------------------------------
module fpfa_fit_unit (
  input  logic [fpfa_pkg::SIZE_BITS-1:0] size,
  input  logic                           busy,
  input  logic [fpfa_pkg::SIZE_BITS-1:0] req,
  input  logic                           found,
  input  logic [fpfa_pkg::SIZE_BITS-1:0] best_diff,
  input  logic [1:0]                     policy,
  output fpfa_pkg::fit_res_t             res
);

  logic [fpfa_pkg::SIZE_BITS:0]   sub;
  logic [fpfa_pkg::SIZE_BITS-1:0] diff;
  logic                           fits;
  logic                           better;

  // Borrow out of the subtract means the request does not fit.
  assign sub  = {1'b0, size} - {1'b0, req};
  assign diff = sub[fpfa_pkg::SIZE_BITS-1:0];
  assign fits = !busy && !sub[fpfa_pkg::SIZE_BITS];

  always_comb begin
    unique case (policy)
      fpfa_pkg::POL_BEST:  better = diff < best_diff;
      fpfa_pkg::POL_WORST: better = diff > best_diff;
      fpfa_pkg::POL_FIRST: better = 1'b1;
      fpfa_pkg::POL_NEXT:  better = 1'b1;
      default:             better = 1'b1;
    endcase
  end

  assign res.take = fits && (!found || better);
  assign res.diff = diff;

endmodule

>>> rtl/core/fpfa_checker.sv
// ----------------------------------------------------------------------------
// fpfa_port_checks: port-level checks for the fit allocator
// Watches the channels of the top level and flags results or handshake
// behavior that the allocator must never show.
// ----------------------------------------------------------------------------
module fpfa_port_checks (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input fpfa_pkg::out_t out_data
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // An accepted transaction keeps the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // A clear resets the running waste and reports no slot and no leftover.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == fpfa_pkg::ST_CLEARED) |->
      (out_data.waste_total == '0) && (out_data.slot == '0) && (out_data.leftover == '0))
    else $error("clear result carries nonzero fields");

  // Refused requests and full-table adds report no slot and no leftover.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == fpfa_pkg::ST_WAITING) ||
                  (out_data.status == fpfa_pkg::ST_FULL)) |->
      (out_data.slot == '0) && (out_data.leftover == '0))
    else $error("refused result carries slot or leftover");

endmodule

bind fixed_partition_fit_allocator_top fpfa_port_checks u_fpfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
